[hw/rtl/bba_pkg.sv]
// shared types and constants of the block bitmap allocator
`default_nettype none

package bba_pkg;

	// default sizes of the occupancy map
	localparam int MAX_BLOCKS_DEF = 16384;
	localparam int WORD_BITS_DEF  = 32;

	// fixed field widths
	localparam int BLK_W      = 14;
	localparam int CNT_W      = 15;
	localparam int KIND_W     = 2;
	localparam int STAT_W     = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 32;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register index as taken from paddr[2]
	localparam logic REG_TOTAL    = 1'b0;
	localparam logic REG_RESERVED = 1'b1;

	// register reset values
	localparam logic [CNT_W-1:0] TOTAL_RST    = 15'd16384;
	localparam logic [CNT_W-1:0] RESERVED_RST = 15'd0;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_TEST    = 2'd2,
		KIND_FORMAT  = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_SCAN,
		S_ADDR,
		S_BITOP,
		S_RESP
	} state_t;

	// register values handed from the configuration port to the controller
	typedef struct packed {
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] reserved;
	} cfg_t;

endpackage

`default_nettype wire

[hw/rtl/bba_map_ram.sv]
// occupancy map memory: one write port, one read port, registered read data
`default_nettype none

module bba_map_ram
	import bba_pkg::*;
#(
	parameter int DEPTH = MAX_BLOCKS_DEF / WORD_BITS_DEF,
	parameter int WIDTH = WORD_BITS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/bba_cfg.sv]
// configuration registers behind the apb-style port
`default_nettype none

module bba_cfg
	import bba_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] reserved_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= TOTAL_RST;
			reserved_q <= RESERVED_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_TOTAL:    total_q    <= pwdata[CNT_W-1:0];
				REG_RESERVED: reserved_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[2])
			REG_TOTAL:    prdata = APB_DATA_W'(total_q);
			REG_RESERVED: prdata = APB_DATA_W'(reserved_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.total    = total_q;
	assign cfg.reserved = reserved_q;

endmodule

`default_nettype wire

[hw/rtl/bba_ctrl.sv]
// request sequencer: map sweep, allocate scan, bit read-modify-write, free count
`default_nettype none

module bba_ctrl
	import bba_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int WORD_BITS  = WORD_BITS_DEF,
	parameter int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS,
	parameter int WA_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_t                 cfg,
	// request side
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire kind_t                in_kind,
	input  wire logic [BLK_W-1:0]     in_block,
	// result side
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [BLK_W-1:0]     out_block_number,
	output logic                      out_bit_value,
	output status_t                   out_status,
	output logic      [CNT_W-1:0]     out_free_count,
	// map memory
	output logic                      mem_we,
	output logic      [WA_W-1:0]      mem_waddr,
	output logic      [WORD_BITS-1:0] mem_wdata,
	output logic                      mem_re,
	output logic      [WA_W-1:0]      mem_raddr,
	input  wire logic [WORD_BITS-1:0] mem_rdata
);

	localparam int WC_W   = $clog2(MAP_WORDS + 1);
	localparam int BIT_W  = $clog2(WORD_BITS);
	localparam int BASE_W = $clog2(MAP_WORDS * WORD_BITS + 1);
	localparam int NW     = ((BASE_W > CNT_W) ? BASE_W : CNT_W) + 1;
	// word index by reciprocal multiply, exact for every block number
	localparam int SH     = BLK_W + BIT_W;
	localparam int RC_W   = SH - 2;
	localparam int PR_W   = BLK_W + RC_W;
	localparam int RECIP  = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;

	// control state
	state_t            state_q, state_d;
	logic [WC_W-1:0]   widx_q;
	logic [WC_W-1:0]   raddr_q;
	logic [NW-1:0]     base_q;
	logic              dvalid_q;
	logic              is_fmt_q;
	logic [CNT_W-1:0]  free_q;
	logic              out_valid_q;

	// payload registers
	kind_t             kind_q;
	logic [BLK_W-1:0]  blk_q;
	logic [BLK_W-1:0]  q_q;
	logic [BIT_W-1:0]  bitpos_q;
	logic [BLK_W-1:0]  rnum_q;
	logic              rbit_q;
	status_t           rstat_q;
	logic [BLK_W-1:0]  onum_q;
	logic              obit_q;
	status_t           ostat_q;
	logic [CNT_W-1:0]  ofree_q;

	// derived values
	logic [NW-1:0]        tot;
	logic [NW-1:0]        res_eff;
	logic [NW-1:0]        res_sw;
	logic [NW-1:0]        base_end;
	logic [NW-1:0]        sw_diff;
	logic [WORD_BITS-1:0] sw_pat;
	logic [NW-1:0]        avail;
	logic [WORD_BITS-1:0] vmask;
	logic [WORD_BITS-1:0] freebits;
	logic [WORD_BITS-1:0] lowbit;
	logic [BIT_W-1:0]     pos;
	logic                 found;
	logic                 last_word;
	logic                 sweep_last;
	logic                 out_free;
	logic [PR_W-1:0]      prod;
	logic [BLK_W-1:0]     qw;
	logic [WORD_BITS-1:0] bmask;
	logic                 in_range;

	// effective register values
	assign tot      = (NW'(cfg.total) > NW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : NW'(cfg.total);
	assign res_eff  = (NW'(cfg.reserved) > tot) ? tot : NW'(cfg.reserved);
	assign in_range = NW'(in_block) < tot;

	// sweep pattern: reserved blocks set, the rest clear
	assign res_sw   = is_fmt_q ? res_eff : '0;
	assign base_end = base_q + NW'(WORD_BITS);
	assign sw_diff  = res_sw - base_q;
	always_comb begin
		priority if (base_end <= res_sw) begin
			sw_pat = '1;
		end else if (base_q >= res_sw) begin
			sw_pat = '0;
		end else begin
			sw_pat = ~({WORD_BITS{1'b1}} << sw_diff[BIT_W-1:0]);
		end
	end
	assign sweep_last = widx_q == WC_W'(MAP_WORDS - 1);

	// allocate search over the word just read
	assign avail = (tot > base_q) ? (tot - base_q) : '0;
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			vmask[b] = NW'(b) < avail;
		end
	end
	assign freebits  = ~mem_rdata & vmask;
	assign found     = |freebits;
	assign lowbit    = freebits & (~freebits + WORD_BITS'(1));
	assign last_word = (base_end >= tot) || sweep_last;
	always_comb begin
		pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (freebits[b]) begin
				pos = BIT_W'(b);
			end
		end
	end

	// word index and bit position of a single-block request
	assign prod  = PR_W'(in_block) * PR_W'(RECIP);
	assign qw    = BLK_W'(q_q * WORD_BITS);
	assign bmask = {{(WORD_BITS - 1){1'b0}}, 1'b1} << bitpos_q;

	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SWEEP: begin
				if (sweep_last) begin
					state_d = is_fmt_q ? S_RESP : S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_kind)
						KIND_FORMAT: state_d = S_SWEEP;
						KIND_ALLOC:  state_d = (free_q == '0) ? S_RESP : S_SCAN;
						default:     state_d = in_range ? S_ADDR : S_RESP;
					endcase
				end
			end
			S_SCAN: begin
				if (dvalid_q && (found || last_word)) begin
					state_d = S_RESP;
				end
			end
			S_ADDR:  state_d = S_BITOP;
			S_BITOP: state_d = S_RESP;
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory and handshake outputs
	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = WA_W'(widx_q);
		mem_wdata = sw_pat;
		mem_re    = 1'b0;
		mem_raddr = WA_W'(raddr_q);
		unique case (state_q)
			S_SWEEP: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_SCAN: begin
				mem_re    = raddr_q < WC_W'(MAP_WORDS);
				mem_we    = dvalid_q && found;
				mem_wdata = mem_rdata | lowbit;
			end
			S_ADDR: begin
				mem_re    = 1'b1;
				mem_raddr = WA_W'(q_q);
			end
			S_BITOP: begin
				mem_we    = kind_q == KIND_RELEASE;
				mem_waddr = WA_W'(q_q);
				mem_wdata = mem_rdata & ~bmask;
			end
			default: ;
		endcase
	end

	// control registers; reset starts the clearing sweep of the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			widx_q      <= '0;
			raddr_q     <= '0;
			base_q      <= '0;
			dvalid_q    <= 1'b0;
			is_fmt_q    <= 1'b0;
			free_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					widx_q <= widx_q + WC_W'(1);
					base_q <= base_end;
					if (sweep_last && is_fmt_q) begin
						free_q <= CNT_W'(tot - res_eff);
					end
				end
				S_IDLE: begin
					widx_q   <= '0;
					raddr_q  <= '0;
					base_q   <= '0;
					dvalid_q <= 1'b0;
					if (in_valid) begin
						is_fmt_q <= in_kind == KIND_FORMAT;
					end
				end
				S_SCAN: begin
					dvalid_q <= mem_re;
					if (mem_re) begin
						raddr_q <= raddr_q + WC_W'(1);
					end
					if (dvalid_q) begin
						widx_q <= widx_q + WC_W'(1);
						base_q <= base_end;
						if (found) begin
							free_q <= free_q - CNT_W'(1);
						end
					end
				end
				S_BITOP: begin
					if (kind_q == KIND_RELEASE && NW'(free_q) < tot) begin
						free_q <= free_q + CNT_W'(1);
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					kind_q  <= in_kind;
					blk_q   <= in_block;
					q_q     <= BLK_W'(prod >> SH);
					rnum_q  <= '0;
					rbit_q  <= 1'b0;
					if (in_kind == KIND_ALLOC && free_q == '0) begin
						rstat_q <= ST_NO_FREE;
					end else if ((in_kind == KIND_RELEASE || in_kind == KIND_TEST)
							&& !in_range) begin
						rstat_q <= ST_RANGE;
					end else begin
						rstat_q <= ST_OK;
					end
				end
			end
			S_SCAN: begin
				if (dvalid_q) begin
					if (found) begin
						rnum_q <= BLK_W'(base_q + NW'(pos));
					end else if (last_word) begin
						rstat_q <= ST_NO_FREE;
					end
				end
			end
			S_ADDR: begin
				bitpos_q <= BIT_W'(blk_q - qw);
			end
			S_BITOP: begin
				rnum_q <= blk_q;
				if (kind_q == KIND_TEST) begin
					rbit_q <= mem_rdata[bitpos_q];
				end
			end
			S_RESP: begin
				if (out_free) begin
					onum_q  <= rnum_q;
					obit_q  <= rbit_q;
					ostat_q <= rstat_q;
					ofree_q <= free_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign out_block_number = onum_q;
	assign out_bit_value    = obit_q;
	assign out_status       = ostat_q;
	assign out_free_count   = ofree_q;

endmodule

`default_nettype wire

[hw/rtl/block_bitmap_allocator_unit.sv]
// top level of the block bitmap allocator
`default_nettype none

// Free-block bitmap allocator. One occupancy bit per block (1 = used) lives in
// a map memory of MAX_BLOCKS/WORD_BITS words (512 by default); a free-block
// count sits in a register. Requests arrive on s_*, one result per request
// leaves on m_*. Requests are handled one at a time. Release does one
// read-modify-write of the map word and test reads it; a block at or above the
// total, or allocate with a zero count, is answered without a map access.
// Allocate reads the map one word per cycle from word 0 and stops at the first
// word with a free block below the total. Format rewrites every map word, one
// per cycle. After reset the map is cleared by the same sweep, and s_tready
// stays low until it ends; the registers can be written meanwhile.
// Configuration writes are expected only while no request is open.
module block_bitmap_allocator_unit
	import bba_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int WORD_BITS  = WORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	// requests
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // block[13:0], zero[15:14]
	input  wire logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
	// results
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata    // block_number[13:0], bit_value[14],
	                                              // status[16:15], free_count[31:17]
);

	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	cfg_t                 cfg;
	logic                 mem_we;
	logic [WA_W-1:0]      mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [WA_W-1:0]      mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;
	logic [BLK_W-1:0]     res_block_number;
	logic                 res_bit_value;
	status_t              res_status;
	logic [CNT_W-1:0]     res_free_count;

	// configuration registers
	bba_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// request sequencer
	bba_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.WORD_BITS  (WORD_BITS),
		.MAP_WORDS  (MAP_WORDS),
		.WA_W       (WA_W)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.in_kind          (kind_t'(s_tuser)),
		.in_block         (s_tdata[BLK_W-1:0]),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_block_number (res_block_number),
		.out_bit_value    (res_bit_value),
		.out_status       (res_status),
		.out_free_count   (res_free_count),
		.mem_we           (mem_we),
		.mem_waddr        (mem_waddr),
		.mem_wdata        (mem_wdata),
		.mem_re           (mem_re),
		.mem_raddr        (mem_raddr),
		.mem_rdata        (mem_rdata)
	);

	// occupancy map
	bba_map_ram #(
		.DEPTH (MAP_WORDS),
		.WIDTH (WORD_BITS),
		.AW    (WA_W)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result packing, first field in the lowest bits
	assign m_tdata = {res_free_count, res_status, res_bit_value, res_block_number};

	// one request at a time: ready drops right after a transaction
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is open");

	// the map is never written while the block waits for a request
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !mem_we)
		else $error("map write while idle");

	// an error result carries no block number and no bit
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_status != ST_OK |-> res_block_number == '0 && !res_bit_value)
		else $error("error result with nonzero block number or bit");

endmodule

`default_nettype wire
